@@ hdl/heightmap_circle_bump_stamper_macros.svh @@
`ifndef HEIGHTMAP_CIRCLE_BUMP_STAMPER_MACROS_SVH
`define HEIGHTMAP_CIRCLE_BUMP_STAMPER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define HCBS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbs check failed");

// Next-cycle implication, sampled on clk, quiet while in reset.
`define HCBS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcbs check failed");

`endif

@@ hdl/hcbs_pkg.sv @@
package hcbs_pkg;

  localparam int HEIGHT_W = 20;
  localparam int COORD_W  = 8;
  localparam int CMD_W    = 2;
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;

  localparam int GRID_SIDE_DEF = 256;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [COORD_W-1:0] GRID_LAST_RST = 8'd30;

  localparam logic [CMD_W-1:0] CMD_STAMP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_GRID_LAST_X = 1'b0;
  localparam logic REG_GRID_LAST_Z = 1'b1;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  // Stamp walk: centre first, then the 44 ring cells with d2 < 16.
  localparam int STEP_COUNT  = 45;
  localparam int STEP_W      = $clog2(STEP_COUNT);
  localparam int SLOT_COUNT  = 9;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int CENTRE_SLOT = 8;

  localparam int STEP_DX [STEP_COUNT] = '{
    0,
    -3, -3, -3, -3, -3,
    -2, -2, -2, -2, -2, -2, -2,
    -1, -1, -1, -1, -1, -1, -1,
    0, 0, 0, 0, 0, 0,
    1, 1, 1, 1, 1, 1, 1,
    2, 2, 2, 2, 2, 2, 2,
    3, 3, 3, 3, 3
  };

  localparam int STEP_DZ [STEP_COUNT] = '{
    0,
    -2, -1, 0, 1, 2,
    -3, -2, -1, 0, 1, 2, 3,
    -3, -2, -1, 0, 1, 2, 3,
    -3, -2, -1, 1, 2, 3,
    -3, -2, -1, 0, 1, 2, 3,
    -3, -2, -1, 0, 1, 2, 3,
    -2, -1, 0, 1, 2
  };

  localparam int STEP_SLOT [STEP_COUNT] = '{
    8,
    7, 6, 5, 6, 7,
    7, 4, 3, 2, 3, 4, 7,
    6, 3, 1, 0, 1, 3, 6,
    5, 2, 0, 0, 2, 5,
    6, 3, 1, 0, 1, 3, 6,
    7, 4, 3, 2, 3, 4, 7,
    7, 6, 5, 6, 7
  };

  // Gains for d2 = 1,2,4,5,8,9,10,13 with 16 fraction bits.
  localparam int BUMP_Q16 [8] = '{63932, 64841, 52029, 43438, 19625, 13507, 8538, 538};

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] z_pos;
  } in_item_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic [HEIGHT_W-1:0] peak;
  } out_item_t;

  typedef struct packed {
    logic                hit;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  z;
    logic [HEIGHT_W-1:0] gain;
  } cell_t;

  // Round half up to the target fraction width.
  function automatic logic [HEIGHT_W-1:0] bump_gain(input int slot, input int frac_bits);
    int shift;
    int half;
    int q;
    shift = 16 - frac_bits;
    half  = (1 << shift) >> 1;
    if (slot == CENTRE_SLOT) begin
      return HEIGHT_W'(1 << frac_bits);
    end
    q = BUMP_Q16[slot];
    return HEIGHT_W'((q + half) >> shift);
  endfunction

endpackage

@@ hdl/hcbs_cell_gen.sv @@
module hcbs_cell_gen import hcbs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [STEP_W-1:0]  step,
  input  logic [COORD_W-1:0] cx,
  input  logic [COORD_W-1:0] cz,
  input  logic [COORD_W-1:0] lim_x,
  input  logic [COORD_W-1:0] lim_z,
  output cell_t              walk_cell
);

  localparam int PW = COORD_W + 2;

  localparam logic [HEIGHT_W-1:0] GAIN [SLOT_COUNT] = '{
    bump_gain(0, FRAC_BITS), bump_gain(1, FRAC_BITS), bump_gain(2, FRAC_BITS),
    bump_gain(3, FRAC_BITS), bump_gain(4, FRAC_BITS), bump_gain(5, FRAC_BITS),
    bump_gain(6, FRAC_BITS), bump_gain(7, FRAC_BITS), bump_gain(8, FRAC_BITS)
  };

  logic signed [PW-1:0] dx;
  logic signed [PW-1:0] dz;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] pz;
  logic [SLOT_W-1:0]    slot;

  assign dx   = signed'(PW'(STEP_DX[step]));
  assign dz   = signed'(PW'(STEP_DZ[step]));
  assign slot = SLOT_W'(STEP_SLOT[step]);

  assign px = signed'({2'b00, cx}) + dx;
  assign pz = signed'({2'b00, cz}) + dz;

  // Sign bit set means the cell fell off the low edge.
  assign walk_cell.hit  = !px[PW-1] && !pz[PW-1] &&
                          (px <= signed'({2'b00, lim_x})) && (pz <= signed'({2'b00, lim_z}));
  assign walk_cell.x    = px[COORD_W-1:0];
  assign walk_cell.z    = pz[COORD_W-1:0];
  assign walk_cell.gain = GAIN[slot];

endmodule

@@ hdl/heightmap_circle_bump_stamper.sv @@
// Circle-bump heightmap stamper. Heights are unsigned 12.8 fixed point held in a
// single-port-read, single-port-write RAM of GRID_SIDE*GRID_SIDE cells; a running
// peak sits beside it. A stamp walks 45 cells (centre plus the ring with d2 < 16),
// one read-modify-write per cycle through the RAM, and holds in_ready low through
// the walk and a drain state. A read passes through a request state, an output state
// and the result register, and waits in the output state while the previous result
// has not been taken. A clear, and likewise the pass after reset, writes zero to every
// RAM cell one per cycle, during which no item is taken. Registers take effect
// on the next item and should be written only while the block is idle.
module heightmap_circle_bump_stamper import hcbs_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIDE_W = $clog2(GRID_SIDE);
  localparam int CMP_W  = (SIDE_W > COORD_W) ? SIDE_W : COORD_W;
  localparam logic [CMP_W-1:0] LIM_CAP = CMP_W'(GRID_SIDE - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_STAMP  = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_RD_REQ = 6'b001000,
    ST_RD_OUT = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [COORD_W-1:0]  grid_last_x_r, grid_last_z_r;
  logic [COORD_W-1:0]  lim_x, lim_z;
  logic [COORD_W-1:0]  cx_r, cz_r;
  logic                rd_ok_r;
  logic [STEP_W-1:0]   step_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic                wb_valid_r;
  logic [ADDR_W-1:0]   wb_addr_r;
  logic [HEIGHT_W-1:0] wb_gain_r;
  logic [HEIGHT_W-1:0] rd_data_r;
  logic [HEIGHT_W-1:0] peak_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [HEIGHT_W-1:0] mem [DEPTH];

  cell_t               walk_cell;
  logic [COORD_W-1:0]  ax, az;
  logic [ADDR_W-1:0]   rd_addr;
  logic                rd_en;
  logic [HEIGHT_W:0]   sum;
  logic [HEIGHT_W-1:0] sat;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [HEIGHT_W-1:0] wr_data;
  logic                accept;
  logic                in_grid;
  logic                out_free;
  logic                cfg_wr;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_GRID_LAST_Z) ? CFG_DW'(grid_last_z_r)
                                                : CFG_DW'(grid_last_x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_last_x_r <= GRID_LAST_RST;
      grid_last_z_r <= GRID_LAST_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GRID_LAST_X) begin
        grid_last_x_r <= pwdata[COORD_W-1:0];
      end else begin
        grid_last_z_r <= pwdata[COORD_W-1:0];
      end
    end
  end

  assign lim_x = (CMP_W'(grid_last_x_r) < LIM_CAP) ? grid_last_x_r : LIM_CAP[COORD_W-1:0];
  assign lim_z = (CMP_W'(grid_last_z_r) < LIM_CAP) ? grid_last_z_r : LIM_CAP[COORD_W-1:0];

  // ---- control ----
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_grid  = (in_data.x_pos <= lim_x) && (in_data.z_pos <= lim_z);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.cmd)
            CMD_STAMP: state_nxt = in_grid ? ST_STAMP : ST_IDLE;
            CMD_READ:  state_nxt = ST_RD_REQ;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STAMP: begin
        if (step_r == STEP_W'(STEP_COUNT - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_IDLE;
      ST_RD_REQ: state_nxt = ST_RD_OUT;
      ST_RD_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      step_r     <= '0;
      clr_addr_r <= '0;
      wb_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wb_valid_r <= (state_r == ST_STAMP) && walk_cell.hit;
      if (state_r == ST_STAMP) begin
        step_r <= step_r + 1'b1;
      end else begin
        step_r <= '0;
      end
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end else begin
        clr_addr_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx_r    <= in_data.x_pos;
      cz_r    <= in_data.z_pos;
      rd_ok_r <= in_grid;
    end
  end

  // ---- cell walk ----
  hcbs_cell_gen #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cell_gen (
    .step      (step_r),
    .cx        (cx_r),
    .cz        (cz_r),
    .lim_x     (lim_x),
    .lim_z     (lim_z),
    .walk_cell (walk_cell)
  );

  assign ax      = (state_r == ST_STAMP) ? walk_cell.x : cx_r;
  assign az      = (state_r == ST_STAMP) ? walk_cell.z : cz_r;
  assign rd_addr = ADDR_W'(ADDR_W'(ax) * ADDR_W'(GRID_SIDE)) + ADDR_W'(az);
  assign rd_en   = ((state_r == ST_STAMP) && walk_cell.hit) ||
                   ((state_r == ST_RD_REQ) && rd_ok_r);

  // ---- write-back: walk cells are all distinct, so read k+1 never hits write k ----
  assign sum     = {1'b0, rd_data_r} + {1'b0, wb_gain_r};
  assign sat     = sum[HEIGHT_W] ? HEIGHT_MAX : sum[HEIGHT_W-1:0];
  assign wr_en   = (state_r == ST_CLEAR) || wb_valid_r;
  assign wr_addr = (state_r == ST_CLEAR) ? clr_addr_r : wb_addr_r;
  assign wr_data = (state_r == ST_CLEAR) ? '0 : sat;

  always_ff @(posedge clk) begin
    wb_addr_r <= rd_addr;
    wb_gain_r <= walk_cell.gain;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      peak_r <= '0;
    end else if (wb_valid_r && (sat > peak_r)) begin
      peak_r <= sat;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_RD_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_RD_OUT) && out_free) begin
      out_data_r.height <= rd_ok_r ? rd_data_r : '0;
      out_data_r.peak   <= peak_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/hcbs_checker.sv @@
`include "heightmap_circle_bump_stamper_macros.svh"

module hcbs_checker import hcbs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      pready
);

  `HCBS_ASSERT_IMP(a_pready_high, 1'b1, pready)

  `HCBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Reads and clears always occupy the block for at least the next cycle.
  `HCBS_ASSERT_NXT(a_busy_after_cmd,
                   in_valid && in_ready && (in_data.cmd == CMD_READ || in_data.cmd == CMD_CLEAR),
                   !in_ready)

  // A new result beat only appears out of a read in progress.
  `HCBS_ASSERT_IMP(a_result_from_read, $rose(out_valid), !$past(in_ready))

endmodule

bind heightmap_circle_bump_stamper hcbs_checker u_hcbs_checker (.*);
